>>> rtl/rdsd_pkg.sv
// ----------------------------------------------------------------------------
// rdsd_pkg
// Shared types and constants of the Rice delta search decoder.
// ----------------------------------------------------------------------------
package rdsd_pkg;

	localparam int VALUE_W    = 64;
	localparam int CHAIN_W    = 32;
	localparam int COUNT_W    = 32;
	localparam int K_W        = 5;
	localparam int OFS_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_RICE_K       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BASE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VALUE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_BUDGET   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 3'd5;

	typedef struct packed {
		logic [K_W-1:0]     rice_k;
		logic [VALUE_W-1:0] block_base;
		logic [VALUE_W-1:0] target_value;
		logic [CHAIN_W-1:0] first_chain;
		logic [COUNT_W-1:0] bit_budget;
		logic [OFS_W-1:0]   start_offset;
	} cfg_t;

	typedef struct packed {
		logic [7:0]       data;
		logic             first;
		logic             last;
		logic [OFS_W-1:0] start;
	} entry_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [CHAIN_W-1:0] chain;
		logic [COUNT_W-1:0] count;
		logic               found;
		logic               fin;
	} result_t;

endpackage

>>> rtl/rdsd_front.sv
// ----------------------------------------------------------------------------
// rdsd_front
// Input side: takes stream beats, tags each with its first bit position and
// holds them in a short queue for the decoder.
// ----------------------------------------------------------------------------
module rdsd_front #(
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,
	input  logic                     s_tuser,
	input  logic                     s_tlast,
	input  logic [rdsd_pkg::OFS_W-1:0] start_offset,
	output logic                     head_valid,
	output rdsd_pkg::entry_t         head,
	input  logic                     pop
);
	import rdsd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             do_pop;
	entry_t           entry_in;

	assign s_tready   = (count_q != CNT_W'(DEPTH));
	assign push       = s_tvalid & s_tready;
	assign head_valid = (count_q != '0);
	assign do_pop     = pop & head_valid;
	assign head       = mem_q[rd_ptr_q];

	always_comb begin
		entry_in.data  = s_tdata;
		entry_in.first = s_tuser;
		entry_in.last  = s_tlast;
		entry_in.start = s_tuser ? start_offset : '0;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/rdsd_back.sv
// ----------------------------------------------------------------------------
// rdsd_back
// Bit-serial Rice decoder: one coded bit per cycle unless fetching or stalled,
// value update and target compare per code, results into an output register.
// ----------------------------------------------------------------------------
module rdsd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rdsd_pkg::cfg_t    cfg,
	input  logic              head_valid,
	input  rdsd_pkg::entry_t  head,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_ready,
	output rdsd_pkg::result_t res
);
	import rdsd_pkg::*;

	typedef enum logic [2:0] {
		ST_FETCH,
		ST_BIT,
		ST_ADD,
		ST_EMIT,
		ST_END
	} state_t;

	state_t             state_q;
	logic [7:0]         byte_q;
	logic               last_q;
	logic [2:0]         idx_q;
	logic [31:0]        quot_q;
	logic [31:0]        rem_q;
	logic [5:0]         left_q;
	logic               in_rem_q;
	logic [VALUE_W-1:0] run_q;
	logic [CHAIN_W-1:0] chain_q;
	logic [COUNT_W-1:0] bits_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               done_q;
	logic [VALUE_W-1:0] code_q;
	logic               out_valid_q;
	result_t            out_q;

	logic               bit_w;
	logic [31:0]        rem_next;
	logic               complete;
	logic [VALUE_W-1:0] code_w;
	logic [33:0]        nb;
	logic               inc;
	logic               stop;
	logic               can_out;
	logic               emit_now;

	assign pop       = (state_q == ST_FETCH) && head_valid;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		bit_w    = byte_q[3'd7 - idx_q];
		rem_next = {rem_q[30:0], bit_w};
		complete = in_rem_q ? (left_q == 6'd1) : (!bit_w && (cfg.rice_k == '0));
		code_w   = ({32'b0, quot_q} << cfg.rice_k) | {32'b0, in_rem_q ? rem_next : rem_q};
		nb       = {2'b0, bits_q} + {29'b0, cfg.rice_k} + {2'b0, quot_q} + 34'd1;
		inc      = (cnt_q != '0);
		stop     = (run_q >= cfg.target_value) || (bits_q >= cfg.bit_budget);
		can_out  = !out_valid_q || res_ready;
		emit_now = can_out && ((state_q == ST_EMIT) || (state_q == ST_END));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FETCH;
			byte_q      <= '0;
			last_q      <= 1'b0;
			idx_q       <= '0;
			quot_q      <= '0;
			rem_q       <= '0;
			left_q      <= '0;
			in_rem_q    <= 1'b0;
			run_q       <= '0;
			chain_q     <= '0;
			bits_q      <= '0;
			cnt_q       <= '0;
			done_q      <= 1'b1;
			code_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && res_ready && !emit_now) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_FETCH: begin
					if (head_valid) begin
						byte_q <= head.data;
						last_q <= head.last;
						idx_q  <= head.start;
						if (head.first) begin
							quot_q   <= '0;
							rem_q    <= '0;
							left_q   <= '0;
							in_rem_q <= 1'b0;
							run_q    <= cfg.block_base;
							chain_q  <= cfg.first_chain;
							bits_q   <= '0;
							cnt_q    <= '0;
							done_q   <= 1'b0;
							state_q  <= ST_BIT;
						end else if (!done_q) begin
							state_q <= ST_BIT;
						end
					end
				end
				ST_BIT: begin
					if (in_rem_q) begin
						rem_q  <= rem_next;
						left_q <= left_q - 6'd1;
						if (complete) begin
							in_rem_q <= 1'b0;
						end
					end else if (bit_w) begin
						if (quot_q != '1) begin
							quot_q <= quot_q + 32'd1;
						end
					end else if (!complete) begin
						in_rem_q <= 1'b1;
						left_q   <= {1'b0, cfg.rice_k};
						rem_q    <= '0;
					end
					if (complete) begin
						code_q  <= code_w;
						state_q <= ST_ADD;
					end else if (idx_q == 3'd7) begin
						state_q <= last_q ? ST_END : ST_FETCH;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				ST_ADD: begin
					run_q   <= run_q + code_q + {{(VALUE_W-1){1'b0}}, inc};
					chain_q <= chain_q + {{(CHAIN_W-1){1'b0}}, inc};
					cnt_q   <= cnt_q + COUNT_W'(1);
					bits_q  <= (nb[33:32] != 2'b0) ? '1 : nb[31:0];
					quot_q  <= '0;
					rem_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (can_out) begin
						out_valid_q <= 1'b1;
						out_q.value <= run_q;
						out_q.chain <= chain_q;
						out_q.count <= cnt_q;
						if (stop) begin
							out_q.found <= (run_q == cfg.target_value);
							out_q.fin   <= 1'b1;
							done_q      <= 1'b1;
							state_q     <= ST_FETCH;
						end else if (idx_q == 3'd7) begin
							out_q.found <= 1'b0;
							out_q.fin   <= last_q;
							done_q      <= last_q;
							state_q     <= ST_FETCH;
						end else begin
							out_q.found <= 1'b0;
							out_q.fin   <= 1'b0;
							idx_q       <= idx_q + 3'd1;
							state_q     <= ST_BIT;
						end
					end
				end
				ST_END: begin
					if (can_out) begin
						out_valid_q <= 1'b1;
						out_q.value <= run_q;
						out_q.chain <= chain_q;
						out_q.count <= cnt_q;
						out_q.found <= 1'b0;
						out_q.fin   <= 1'b1;
						done_q      <= 1'b1;
						state_q     <= ST_FETCH;
					end
				end
				default: state_q <= ST_FETCH;
			endcase
		end
	end

endmodule

>>> rtl/rice_delta_search_decoder.sv
// ----------------------------------------------------------------------------
// rice_delta_search_decoder
// Searches one block of a Rice-coded sorted list for a target value.
// ----------------------------------------------------------------------------
// Usage:
//   Program the registers through cfg_we/cfg_index/cfg_wdata while idle, then
//   stream the block's bytes on the s_ channel, MSB first. s_tuser marks the
//   byte that starts a search, s_tlast the final byte available.
//   Each completed code gives one beat on the m_ channel, as does a stream end
//   after an unfinished code: value, chain id and code count in m_tdata, the
//   found flag in m_tuser; m_tlast marks the final beat of the search.
// Timing:
//   The decoder handles one coded bit per cycle unless it is fetching a byte,
//   updating the value or waiting on the output. Each byte takes a queue
//   fetch and then its bit steps, plus a value update and a target compare
//   step per completed code. A taken beat's result is registered after the
//   queue, fetch, bit steps up to the completing bit, update and compare.
//   Bytes are queued QUEUE_DEPTH deep, so input continues during decoding.
// Reset and stalls:
//   Reset clears the registers and leaves the decoder idle until a start byte.
//   While m_tready is low one result is held; decoding continues until the
//   next result is due, then the queue fills and s_tready drops.
// ----------------------------------------------------------------------------
module rice_delta_search_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] stream_byte
	input  logic                           s_tuser,   // [0] first_byte
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [127:0]                   m_tdata,   // [63:0] decoded_value,
	                                                  // [95:64] chain_index,
	                                                  // [127:96] codes_decoded
	output logic                           m_tuser,   // [0] found
	output logic                           m_tlast,
	input  logic                           cfg_we,
	input  logic [rdsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rdsd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import rdsd_pkg::*;

	cfg_t    cfg_q;
	logic    head_valid;
	entry_t  head;
	logic    pop;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RICE_K:       cfg_q.rice_k       <= cfg_wdata[K_W-1:0];
				CFG_BLOCK_BASE:   cfg_q.block_base   <= cfg_wdata;
				CFG_TARGET_VALUE: cfg_q.target_value <= cfg_wdata;
				CFG_FIRST_CHAIN:  cfg_q.first_chain  <= cfg_wdata[CHAIN_W-1:0];
				CFG_BIT_BUDGET:   cfg_q.bit_budget   <= cfg_wdata[COUNT_W-1:0];
				CFG_START_OFFSET: cfg_q.start_offset <= cfg_wdata[OFS_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	rdsd_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.s_tlast      (s_tlast),
		.start_offset (cfg_q.start_offset),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop)
	);

	rdsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = {res.count, res.chain, res.value};
	assign m_tuser = res.found;
	assign m_tlast = res.fin;

endmodule

>>> tb/rice_delta_search_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rice_delta_search_decoder_tb
// Drives Rice-coded search streams into the decoder and checks every result
// beat against a bit-level decoder model kept in the bench. Stimulus is a
// short hand-written set of corner streams followed by randomly encoded
// searches over a dozen register settings, with random source gaps and
// sink stalls.
// ----------------------------------------------------------------------------
module rice_delta_search_decoder_tb;

	import rdsd_pkg::*;

	localparam int DRAIN_CYCLES = 150;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} stream_beat_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;
	logic                 s_tuser   = 1'b0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [127:0]         m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// stimulus and expected beats
	stream_beat_t pending_beats[$];
	result_t      due_codes[$];
	bit           enc_bits[$];
	stream_beat_t next_beat;

	// decoder model state
	cfg_t          live_regs    = '0;
	logic [31:0]   unary_count  = '0;
	logic [31:0]   rem_bits     = '0;
	logic [5:0]    rem_left     = '0;
	logic          in_rem       = 1'b0;
	logic [63:0]   run_value    = '0;
	logic [31:0]   run_chain    = '0;
	logic [31:0]   bits_spent   = '0;
	logic [31:0]   codes_seen   = '0;
	logic          search_idle  = 1'b1;

	int unsigned idle_mode      = 0;
	int unsigned phase_items    = 0;
	int unsigned beats_taken    = 0;
	int unsigned beats_checked  = 0;
	int unsigned mismatches     = 0;
	int unsigned hits           = 0;
	int unsigned misses         = 0;
	int unsigned settings_run   = 0;

	rice_delta_search_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// one accepted byte: decode bit by bit, queue one result per code, plus one if the stream ends mid-code
	function automatic void decode_byte(input logic [7:0] data, input logic first,
			input logic last);
		int unsigned b0;
		int unsigned n;
		logic        bitv;
		logic        complete;
		logic        ended_on_code;
		logic        stop;
		logic [4:0]  k;
		logic [63:0] code;
		logic [63:0] nb;
		result_t     held;
		logic        have_held;
		b0 = 0;
		n = 0;
		ended_on_code = 1'b0;
		have_held = 1'b0;
		held = '0;
		if (first) begin
			unary_count = '0;
			rem_bits = '0;
			rem_left = '0;
			in_rem = 1'b0;
			bits_spent = '0;
			codes_seen = '0;
			run_value = live_regs.block_base;
			run_chain = live_regs.first_chain;
			search_idle = 1'b0;
			b0 = live_regs.start_offset;
		end
		if (search_idle)
			return;
		for (int unsigned b = b0; b < 8 && !search_idle; b++) begin
			bitv = data[7-b];
			complete = 1'b0;
			k = live_regs.rice_k;
			ended_on_code = 1'b0;
			if (!in_rem) begin
				if (bitv) begin
					if (unary_count != 32'hFFFF_FFFF)
						unary_count++;
				end else if (k == 0) begin
					complete = 1'b1;
				end else begin
					in_rem = 1'b1;
					rem_left = 6'(k);
					rem_bits = '0;
				end
			end else begin
				rem_bits = {rem_bits[30:0], bitv};
				rem_left = rem_left - 6'd1;
				if (rem_left == 0) begin
					in_rem = 1'b0;
					complete = 1'b1;
				end
			end
			if (complete) begin
				code = (64'(unary_count) << k) | 64'(rem_bits);
				nb = 64'(bits_spent) + 64'(k) + 64'(unary_count) + 64'd1;
				bits_spent = (nb > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nb[31:0];
				if (codes_seen == 0) begin
					run_value += code;
				end else begin
					run_value += code + 64'd1;
					run_chain++;
				end
				codes_seen++;
				unary_count = '0;
				rem_bits = '0;
				stop = (run_value >= live_regs.target_value) ||
					(bits_spent >= live_regs.bit_budget);
				if (have_held)
					due_codes.push_back(held);
				held.value = run_value;
				held.chain = run_chain;
				held.count = codes_seen;
				held.found = stop && (run_value == live_regs.target_value);
				held.fin = stop;
				have_held = 1'b1;
				if (stop)
					search_idle = 1'b1;
				n++;
				ended_on_code = 1'b1;
			end
		end
		// stream ran out before the search stopped
		if (last && !search_idle) begin
			if (ended_on_code && n > 0) begin
				held.found = 1'b0;
				held.fin = 1'b1;
			end else if (n < 8) begin
				if (have_held)
					due_codes.push_back(held);
				held.value = run_value;
				held.chain = run_chain;
				held.count = codes_seen;
				held.found = 1'b0;
				held.fin = 1'b1;
				have_held = 1'b1;
			end
			search_idle = 1'b1;
		end
		if (have_held)
			due_codes.push_back(held);
	endfunction

	function automatic void check_beat();
		result_t got;
		result_t want;
		got.value = m_tdata[63:0];
		got.chain = m_tdata[95:64];
		got.count = m_tdata[127:96];
		got.found = m_tuser;
		got.fin = m_tlast;
		beats_checked++;
		if (due_codes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result beat: value %h chain %h count %0d found %b last %b",
					got.value, got.chain, got.count, got.found, got.fin);
			return;
		end
		want = due_codes.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: exp value %h chain %h count %0d found %b last %b",
					want.value, want.chain, want.count, want.found, want.fin);
				$display("          got value %h chain %h count %0d found %b last %b",
					got.value, got.chain, got.count, got.found, got.fin);
			end
		end else if (want.fin) begin
			if (want.found)
				hits++;
			else
				misses++;
		end
	endfunction

	function automatic bit sender_gap();
		case (idle_mode)
			1: return $urandom_range(0, 99) < 75;
			3: return $urandom_range(0, 99) < 20;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stall();
		case (idle_mode)
			2: return $urandom_range(0, 99) < 75;
			3: return $urandom_range(0, 99) < 20;
			default: return 1'b0;
		endcase
	endfunction

	// source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tuser, s_tlast);
				beats_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_beats.size() != 0 && !sender_gap()) begin
					next_beat = pending_beats.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_beat.data;
					s_tuser <= next_beat.first;
					s_tlast <= next_beat.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_beat();
			m_tready <= !receiver_stall();
		end
	end

	function automatic void queue_beat(input logic [7:0] data, input logic first,
			input logic last);
		stream_beat_t sb;
		sb.data = data;
		sb.first = first;
		sb.last = last;
		pending_beats.push_back(sb);
		phase_items++;
	endfunction

	function automatic void put_bits(input logic [63:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			enc_bits.push_back(v[i]);
	endfunction

	function automatic void put_code(input logic [63:0] c);
		int unsigned q;
		q = int'(c >> live_regs.rice_k);
		repeat (q) enc_bits.push_back(1'b1);
		enc_bits.push_back(1'b0);
		put_bits(c, live_regs.rice_k);
	endfunction

	// pad to whole bytes and queue them as one search
	function automatic void flush_search(input bit mark_last);
		logic [7:0] d;
		int         nbytes;
		while (enc_bits.size() % 8 != 0)
			enc_bits.push_back(1'($urandom_range(0, 1)));
		nbytes = enc_bits.size() / 8;
		for (int i = 0; i < nbytes; i++) begin
			for (int j = 7; j >= 0; j--)
				d[j] = enc_bits.pop_front();
			queue_beat(d, i == 0, mark_last && (i == nbytes - 1));
		end
	endfunction

	function automatic void truncate_bits();
		int unsigned len;
		len = $urandom_range(1, enc_bits.size());
		while (enc_bits.size() > len)
			void'(enc_bits.pop_back());
	endfunction

	// encode a plausible sorted run, steering some codes onto the target
	function automatic void gen_search();
		logic [63:0] val;
		logic [63:0] need;
		logic [63:0] code;
		logic [63:0] kmask;
		logic [4:0]  k;
		int unsigned n_max;
		int unsigned cnt;
		k = live_regs.rice_k;
		kmask = (64'd1 << k) - 64'd1;
		n_max = (k > 16) ? $urandom_range(1, 3) : $urandom_range(1, 10);
		val = live_regs.block_base;
		cnt = 0;
		put_bits(rand64(), live_regs.start_offset);
		while (cnt < n_max && (cnt == 0 || val < live_regs.target_value)) begin
			need = live_regs.target_value - val - ((cnt != 0) ? 64'd1 : 64'd0);
			if (val < live_regs.target_value && (need >> k) <= 6 &&
					$urandom_range(0, 2) != 0)
				code = need + (($urandom_range(0, 3) == 0) ? 64'd1 : 64'd0);
			else
				code = (64'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 12 : 3)) << k) |
					(rand64() & kmask);
			put_code(code);
			val += code + ((cnt != 0) ? 64'd1 : 64'd0);
			cnt++;
		end
		case ($urandom_range(0, 5))
			0, 1: flush_search(1'b0);
			2: flush_search(1'b1);
			3: begin
				truncate_bits();
				flush_search(1'b1);
			end
			4: begin
				flush_search(1'b0);
				queue_beat(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
			end
			default: begin
				truncate_bits();
				flush_search(1'b0);
			end
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
	endtask

	task automatic program_regs(input cfg_t c);
		live_regs = c;
		write_reg(CFG_RICE_K, 64'(c.rice_k));
		write_reg(CFG_BLOCK_BASE, c.block_base);
		write_reg(CFG_TARGET_VALUE, c.target_value);
		write_reg(CFG_FIRST_CHAIN, 64'(c.first_chain));
		write_reg(CFG_BIT_BUDGET, 64'(c.bit_budget));
		write_reg(CFG_START_OFFSET, 64'(c.start_offset));
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	task automatic wait_idle();
		while (pending_beats.size() != 0 || s_tvalid || due_codes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		cfg_t        c;
		int unsigned flavor;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// k = 0, chain ids wrap, stream-end and restart cases
		c.rice_k = 5'd0;
		c.block_base = 64'd10;
		c.target_value = '1;
		c.first_chain = 32'hFFFF_FFFD;
		c.bit_budget = '1;
		c.start_offset = 3'd0;
		program_regs(c);
		queue_beat(8'h00, 1'b1, 1'b0);
		queue_beat(8'hFF, 1'b0, 1'b0);
		queue_beat(8'h55, 1'b0, 1'b0);
		queue_beat(8'hA5, 1'b0, 1'b1);
		queue_beat(8'h12, 1'b0, 1'b0);
		queue_beat(8'h00, 1'b1, 1'b1);
		queue_beat(8'hF0, 1'b1, 1'b0);
		queue_beat(8'hFF, 1'b1, 1'b0);
		queue_beat(8'hFF, 1'b0, 1'b1);
		wait_idle();

		// zero budget, max offset, value wraps past 2^64
		c.rice_k = 5'd3;
		c.block_base = 64'hFFFF_FFFF_FFFF_FFFA;
		c.target_value = '1;
		c.first_chain = 32'd0;
		c.bit_budget = 32'd0;
		c.start_offset = 3'd7;
		program_regs(c);
		queue_beat(8'h01, 1'b1, 1'b0);
		queue_beat(8'h3F, 1'b0, 1'b0);
		queue_beat(8'h77, 1'b0, 1'b0);
		queue_beat(8'h00, 1'b1, 1'b0);
		queue_beat(8'hE0, 1'b0, 1'b1);
		wait_idle();

		// widest remainder, exact target hits
		c.rice_k = 5'd31;
		c.block_base = 64'd0;
		c.target_value = 64'hD234_5678;
		c.first_chain = 32'h8000_0000;
		c.bit_budget = '1;
		c.start_offset = 3'd3;
		program_regs(c);
		put_bits(64'b101, 3);
		put_code(c.target_value);
		flush_search(1'b1);
		put_bits(64'b000, 3);
		put_code(64'h1234);
		put_code(c.target_value - 64'h1234 - 64'd1);
		flush_search(1'b0);
		wait_idle();

		for (int p = 0; p < 12; p++) begin
			flavor = p % 6;
			case (flavor)
				0: c.rice_k = 5'd0;
				1: c.rice_k = 5'($urandom_range(1, 4));
				2: c.rice_k = 5'd31;
				3: c.rice_k = 5'($urandom_range(0, 31));
				4: c.rice_k = 5'($urandom_range(1, 8));
				default: c.rice_k = 5'($urandom_range(0, 3));
			endcase
			if (flavor == 5)
				c.block_base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 60));
			else if (flavor == 0)
				c.block_base = '0;
			else
				c.block_base = rand64();
			if (flavor == 5)
				c.target_value = '1;
			else
				c.target_value = c.block_base +
					((64'($urandom_range(0, 40)) << c.rice_k) |
					(rand64() & ((64'd1 << c.rice_k) - 64'd1)));
			c.first_chain = (flavor == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom;
			if (flavor == 3)
				c.bit_budget = $urandom_range(0, 40);
			else if (flavor == 4)
				c.bit_budget = $urandom_range(10, 200);
			else
				c.bit_budget = '1;
			c.start_offset = 3'($urandom_range(0, 7));
			program_regs(c);
			idle_mode = p % 4;
			phase_items = 0;
			while (phase_items < 35) begin
				if ($urandom_range(0, 9) == 0)
					queue_beat(8'($urandom), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				else
					gen_search();
			end
			wait_idle();
		end

		$display("Sent %0d stream beats over %0d register settings, checked %0d result beats",
			beats_taken, settings_run, beats_checked);
		$display("%0d searches ended on the target, %0d ended without it", hits, misses);
		if (mismatches == 0 && due_codes.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/rdsd_pkg.sv
rtl/rdsd_front.sv
rtl/rdsd_back.sv
rtl/rice_delta_search_decoder.sv
tb/rice_delta_search_decoder_tb.sv
